// ===== hdl/bgms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgms_pkg
// Shared types and constants for the binary grid majority smoother.
// ----------------------------------------------------------------------------
package bgms_pkg;

    // Grid geometry defaults
    localparam int GRID_ROWS_DEF = 32;
    localparam int GRID_COLS_DEF = 64;

    // Port field widths
    localparam int OP_W    = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 6;
    localparam int PASS_W  = 3;
    localparam int THR_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Width used to compare an address against a grid dimension (up to 256)
    localparam int DIM_CMP_W = 9;

    // Opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_THR  = 2'd2;

    // Configuration reset values
    localparam logic [PASS_W-1:0] PASS_TOTAL_RST = 3'd2;
    localparam logic [THR_W-1:0]  WALL_THR_RST   = 4'd5;
    localparam logic [THR_W-1:0]  FLOOR_THR_RST  = 4'd5;

    // Neighbor count: eight neighbors
    localparam logic [THR_W-1:0] NEIGHBOR_TOTAL = 4'd8;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_PREV,
        ST_LD_CUR,
        ST_LD_NXT,
        ST_CELL,
        ST_WB,
        ST_LD_ROW,
        ST_CELLOP,
        ST_RESP
    } state_t;

    // Rule thresholds handed to the cell rule
    typedef struct packed {
        logic [THR_W-1:0] wall_thr;
        logic [THR_W-1:0] floor_thr;
    } thr_t;

endpackage
`default_nettype wire

// ===== hdl/binary_grid_majority_smoother_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_grid_majority_smoother_core
// Binary cell grid held as one row-wide RAM; cell write/read and in-place
// raster-order smoothing passes.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Dir
//  ---------+-------------------------------------------+-----
//  in       | in_valid, in_ready, opcode, row, col,     | in
//           | cell_in                                   |
//  out      | out_valid, out_ready, cell_out, done_res  | out
//  cfg      | cfg_we, cfg_index, cfg_data               | in
//
//  Write and read first read the row from the RAM, then do the bit merge and
//  write-back (or bit select). A run makes pass_total raster passes over the
//  interior, one interior cell per cycle in the rule unit, with one write-back
//  and one row fetch per row. Reset sets control and configuration to their
//  reset values; grid contents are undefined until written. A result waits in
//  the output register; the sequencer holds in its last state while that
//  register is still full.
// ----------------------------------------------------------------------------
module binary_grid_majority_smoother_core
#(
    parameter int GRID_ROWS = bgms_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = bgms_pkg::GRID_COLS_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [bgms_pkg::OP_W-1:0]       opcode,
    input  wire logic [bgms_pkg::ROW_W-1:0]      row,
    input  wire logic [bgms_pkg::COL_W-1:0]      col,
    input  wire logic                            cell_in,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 cell_out,
    output logic                                 done_res,

    input  wire logic                            cfg_we,
    input  wire logic [bgms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bgms_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam logic [RW-1:0] ROW_LAST  = RW'(GRID_ROWS - 2);
    localparam logic [CW-1:0] COL_LAST  = CW'(GRID_COLS - 2);
    localparam logic [RW-1:0] ROW_FIRST = RW'(1);
    localparam logic [CW-1:0] COL_FIRST = CW'(1);

    // Configuration
    logic [bgms_pkg::PASS_W-1:0] pass_total_reg;
    bgms_pkg::thr_t              thr_reg;

    // Sequencer
    bgms_pkg::state_t            state_reg;
    bgms_pkg::state_t            state_next;
    logic [bgms_pkg::PASS_W-1:0] pass_cnt_reg;
    logic [RW-1:0]               row_reg;
    logic [CW-1:0]               col_reg;

    // Latched command
    logic [bgms_pkg::OP_W-1:0]   op_reg;
    logic [RW-1:0]               lat_row_reg;
    logic [CW-1:0]               lat_col_reg;
    logic                        lat_val_reg;
    logic                        lat_inside_reg;

    // Row window
    logic [GRID_COLS-1:0]        prev_reg;
    logic [GRID_COLS-1:0]        cur_reg;
    logic [GRID_COLS-1:0]        nxt_reg;

    // RAM
    logic [GRID_COLS-1:0]        grid_mem [GRID_ROWS];
    logic [GRID_COLS-1:0]        rd_data_reg;
    logic [RW-1:0]               rd_addr;
    logic                        mem_we;
    logic [RW-1:0]               wr_addr;
    logic [GRID_COLS-1:0]        wr_data;
    logic [GRID_COLS-1:0]        merged_row;

    // Output register
    logic                        out_valid_reg;
    logic                        cell_out_reg;
    logic                        out_load;
    logic                        out_bit;
    logic                        slot_free;

    // Decode
    logic                        in_xfer;
    logic                        in_inside;
    logic [RW-1:0]               in_row_addr;
    logic [CW-1:0]               in_col_addr;
    logic [bgms_pkg::DIM_CMP_W-1:0] row_ext;
    logic [bgms_pkg::DIM_CMP_W-1:0] col_ext;
    logic                        col_last;
    logic                        row_last;
    logic                        pass_last;
    logic [7:0]                  neighbors;
    logic                        new_bit;
    logic [CW-1:0]               col_m1;
    logic [CW-1:0]               col_p1;

    // Address decode of the incoming command
    assign row_ext     = {{(bgms_pkg::DIM_CMP_W-bgms_pkg::ROW_W){1'b0}}, row};
    assign col_ext     = {{(bgms_pkg::DIM_CMP_W-bgms_pkg::COL_W){1'b0}}, col};
    assign in_inside   = (row_ext < bgms_pkg::DIM_CMP_W'(GRID_ROWS)) &&
                         (col_ext < bgms_pkg::DIM_CMP_W'(GRID_COLS));
    assign in_row_addr = row_ext[RW-1:0];
    assign in_col_addr = col_ext[CW-1:0];
    assign in_xfer     = in_valid && in_ready;

    assign col_last  = (col_reg == COL_LAST);
    assign row_last  = (row_reg == ROW_LAST);
    assign pass_last = ((pass_cnt_reg + bgms_pkg::PASS_W'(1)) == pass_total_reg);
    assign slot_free = !out_valid_reg || out_ready;

    // Neighborhood of the current cell
    assign col_m1 = col_reg - CW'(1);
    assign col_p1 = col_reg + CW'(1);
    assign neighbors = {prev_reg[col_m1], prev_reg[col_reg], prev_reg[col_p1],
                        cur_reg[col_m1],  cur_reg[col_p1],
                        nxt_reg[col_m1],  nxt_reg[col_reg],  nxt_reg[col_p1]};

    bgms_rule u_rule
    (
        .neighbors (neighbors),
        .cur_bit   (cur_reg[col_reg]),
        .thr       (thr_reg),
        .new_bit   (new_bit)
    );

    // Bit merge for a cell write
    always_comb
    begin
        merged_row              = rd_data_reg;
        merged_row[lat_col_reg] = lat_val_reg;
    end

    // Row RAM with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bgms_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == bgms_pkg::OP_RUN)
                    begin
                        state_next = (pass_total_reg == '0) ? bgms_pkg::ST_RESP
                                                            : bgms_pkg::ST_LD_PREV;
                    end
                    else
                    begin
                        state_next = bgms_pkg::ST_CELLOP;
                    end
                end
            end
            bgms_pkg::ST_LD_PREV: state_next = bgms_pkg::ST_LD_CUR;
            bgms_pkg::ST_LD_CUR:  state_next = bgms_pkg::ST_LD_NXT;
            bgms_pkg::ST_LD_NXT:  state_next = bgms_pkg::ST_CELL;
            bgms_pkg::ST_CELL:
            begin
                if (col_last)
                begin
                    state_next = bgms_pkg::ST_WB;
                end
            end
            bgms_pkg::ST_WB:
            begin
                if (!row_last)
                begin
                    state_next = bgms_pkg::ST_LD_ROW;
                end
                else if (pass_last)
                begin
                    state_next = bgms_pkg::ST_RESP;
                end
                else
                begin
                    state_next = bgms_pkg::ST_LD_PREV;
                end
            end
            bgms_pkg::ST_LD_ROW:  state_next = bgms_pkg::ST_CELL;
            bgms_pkg::ST_CELLOP,
            bgms_pkg::ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = bgms_pkg::ST_IDLE;
                end
            end
            default:              state_next = bgms_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        rd_addr  = '0;
        mem_we   = 1'b0;
        wr_addr  = row_reg;
        wr_data  = cur_reg;
        out_load = 1'b0;
        out_bit  = 1'b0;
        unique case (state_reg)
            bgms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = (opcode == bgms_pkg::OP_RUN) ? '0 : in_row_addr;
            end
            bgms_pkg::ST_LD_PREV: rd_addr = RW'(1);
            bgms_pkg::ST_LD_CUR:  rd_addr = RW'(2);
            bgms_pkg::ST_WB:
            begin
                mem_we  = 1'b1;
                rd_addr = row_last ? '0 : (row_reg + RW'(2));
            end
            bgms_pkg::ST_CELLOP:
            begin
                rd_addr  = lat_row_reg;
                wr_addr  = lat_row_reg;
                wr_data  = merged_row;
                mem_we   = slot_free && lat_inside_reg && (op_reg == bgms_pkg::OP_WRITE);
                out_load = slot_free;
                if (op_reg == bgms_pkg::OP_WRITE)
                begin
                    out_bit = lat_val_reg;
                end
                else if (op_reg == bgms_pkg::OP_READ)
                begin
                    out_bit = lat_inside_reg && rd_data_reg[lat_col_reg];
                end
            end
            bgms_pkg::ST_RESP:    out_load = slot_free;
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= bgms_pkg::ST_IDLE;
            pass_cnt_reg       <= '0;
            row_reg            <= ROW_FIRST;
            col_reg            <= COL_FIRST;
            out_valid_reg      <= 1'b0;
            pass_total_reg     <= bgms_pkg::PASS_TOTAL_RST;
            thr_reg.wall_thr   <= bgms_pkg::WALL_THR_RST;
            thr_reg.floor_thr  <= bgms_pkg::FLOOR_THR_RST;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bgms_pkg::CFG_PASS_TOTAL: pass_total_reg    <= cfg_data[bgms_pkg::PASS_W-1:0];
                    bgms_pkg::CFG_WALL_THR:   thr_reg.wall_thr  <= cfg_data;
                    bgms_pkg::CFG_FLOOR_THR:  thr_reg.floor_thr <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // Row and column walk
            if (state_reg == bgms_pkg::ST_LD_NXT)
            begin
                row_reg <= ROW_FIRST;
                col_reg <= COL_FIRST;
            end
            else if (state_reg == bgms_pkg::ST_CELL && !col_last)
            begin
                col_reg <= col_p1;
            end
            else if (state_reg == bgms_pkg::ST_LD_ROW)
            begin
                col_reg <= COL_FIRST;
            end
            else if (state_reg == bgms_pkg::ST_WB && !row_last)
            begin
                row_reg <= row_reg + RW'(1);
            end

            // Pass count, zero between commands
            if (state_reg == bgms_pkg::ST_WB && row_last)
            begin
                pass_cnt_reg <= pass_last ? '0 : (pass_cnt_reg + bgms_pkg::PASS_W'(1));
            end

            // Output register handshake
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg         <= opcode;
            lat_row_reg    <= in_row_addr;
            lat_col_reg    <= in_col_addr;
            lat_val_reg    <= cell_in;
            lat_inside_reg <= in_inside;
        end

        unique case (state_reg)
            bgms_pkg::ST_LD_PREV: prev_reg <= rd_data_reg;
            bgms_pkg::ST_LD_CUR:  cur_reg  <= rd_data_reg;
            bgms_pkg::ST_LD_NXT,
            bgms_pkg::ST_LD_ROW:  nxt_reg  <= rd_data_reg;
            bgms_pkg::ST_CELL:    cur_reg[col_reg] <= new_bit;
            bgms_pkg::ST_WB:
            begin
                if (!row_last)
                begin
                    prev_reg <= cur_reg;
                    cur_reg  <= nxt_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            cell_out_reg <= out_bit;
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign done_res  = 1'b1;

endmodule
`default_nettype wire

// ===== hdl/bgms_rule.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgms_rule
// Counts wall neighbors of one cell and applies the wall and floor rules.
// ----------------------------------------------------------------------------
module bgms_rule
(
    input  wire logic [7:0]         neighbors,
    input  wire logic               cur_bit,
    input  wire bgms_pkg::thr_t     thr,
    output logic                    new_bit
);

    logic [bgms_pkg::THR_W-1:0] wall_cnt;
    logic [bgms_pkg::THR_W-1:0] floor_cnt;

    // Population count of the eight neighbors
    always_comb
    begin
        wall_cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            wall_cnt = wall_cnt + {{(bgms_pkg::THR_W-1){1'b0}}, neighbors[i]};
        end
    end

    assign floor_cnt = bgms_pkg::NEIGHBOR_TOTAL - wall_cnt;

    // Floor rule wins over wall rule
    always_comb
    begin
        new_bit = cur_bit;
        if (wall_cnt >= thr.wall_thr)
        begin
            new_bit = 1'b1;
        end
        if (floor_cnt >= thr.floor_thr)
        begin
            new_bit = 1'b0;
        end
    end

endmodule
`default_nettype wire
